// ===== design/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types, constants and the usage-to-set-1 lookup for the HID report
// to scan code translator.
// ----------------------------------------------------------------------------
`default_nettype none

package hrs_pkg;

  // number of key usage slots in a boot report, and how many are honored
  localparam int SLOT_MAX  = 6;
  localparam int KEY_SLOTS = 6;

  localparam logic [7:0] BREAK_BIT = 8'h80;

  localparam logic [7:0] LCTRL_MAKE  = 8'h1D;
  localparam logic [7:0] LCTRL_BREAK = 8'h9D;
  localparam logic [7:0] LSHFT_MAKE  = 8'h2A;
  localparam logic [7:0] LSHFT_BREAK = 8'hAA;
  localparam logic [7:0] LALT_MAKE   = 8'h38;
  localparam logic [7:0] LALT_BREAK  = 8'hB8;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_CODE  = 2'd1,
    STAT_NODEV = 2'd2
  } status_t;

  typedef logic [SLOT_MAX-1:0][7:0] slots_t;

  // HID keyboard usage to set 1 make code; unmapped usages give 0
  function automatic logic [7:0] usage_to_set1(input logic [7:0] usage);
    logic [7:0] code;
    unique case (usage)
      8'h04: code = 8'h1E;  8'h05: code = 8'h1F;  8'h06: code = 8'h20;
      8'h07: code = 8'h21;  8'h08: code = 8'h22;  8'h09: code = 8'h23;
      8'h0A: code = 8'h24;  8'h0B: code = 8'h25;  8'h0C: code = 8'h26;
      8'h0D: code = 8'h27;  8'h0E: code = 8'h28;  8'h0F: code = 8'h29;
      8'h10: code = 8'h2A;  8'h11: code = 8'h2B;  8'h12: code = 8'h2C;
      8'h13: code = 8'h2D;  8'h14: code = 8'h2E;  8'h15: code = 8'h2F;
      8'h16: code = 8'h30;  8'h17: code = 8'h31;  8'h18: code = 8'h32;
      8'h19: code = 8'h33;  8'h1A: code = 8'h34;  8'h1B: code = 8'h35;
      8'h1C: code = 8'h36;  8'h1D: code = 8'h37;  8'h1E: code = 8'h01;
      8'h1F: code = 8'h03;  8'h20: code = 8'h05;  8'h21: code = 8'h07;
      8'h22: code = 8'h09;  8'h23: code = 8'h0B;  8'h24: code = 8'h0D;
      8'h25: code = 8'h0F;  8'h26: code = 8'h11;  8'h27: code = 8'h13;
      8'h28: code = 8'h1C;  8'h29: code = 8'h01;  8'h2A: code = 8'h0E;
      8'h2B: code = 8'h0F;  8'h2C: code = 8'h2C;  8'h2D: code = 8'h2D;
      8'h2E: code = 8'h01;  8'h2F: code = 8'h10;  8'h30: code = 8'h11;
      8'h31: code = 8'h12;  8'h32: code = 8'h13;  8'h33: code = 8'h17;
      8'h34: code = 8'h18;  8'h35: code = 8'h19;  8'h36: code = 8'h15;
      8'h37: code = 8'h2E;  8'h38: code = 8'h1A;  8'h39: code = 8'h3A;
      8'h3A: code = 8'h3E;  8'h3B: code = 8'h3C;  8'h3C: code = 8'h3D;
      8'h3D: code = 8'h3F;  8'h3E: code = 8'h41;  8'h3F: code = 8'h42;
      8'h40: code = 8'h43;  8'h41: code = 8'h44;  8'h42: code = 8'h45;
      8'h43: code = 8'h46;  8'h44: code = 8'h57;  8'h45: code = 8'h58;
      8'h46: code = 8'h37;  8'h47: code = 8'h48;  8'h48: code = 8'h49;
      8'h49: code = 8'h4A;  8'h4A: code = 8'h4B;  8'h4B: code = 8'h51;
      8'h4C: code = 8'h4D;  8'h4D: code = 8'h4E;  8'h4E: code = 8'h4C;
      8'h4F: code = 8'h50;  8'h50: code = 8'h4F;  8'h51: code = 8'h52;
      8'h52: code = 8'h53;  8'h53: code = 8'h47;  8'h54: code = 8'h4B;
      8'h55: code = 8'h4C;  8'h56: code = 8'h4D;  8'h57: code = 8'h47;
      8'h58: code = 8'h49;  8'h59: code = 8'h51;  8'h5A: code = 8'h4F;
      8'h5B: code = 8'h50;  8'h5C: code = 8'h51;  8'h5D: code = 8'h52;
      8'h5E: code = 8'h4F;  8'h5F: code = 8'h50;  8'h60: code = 8'h51;
      8'h61: code = 8'h52;  8'h62: code = 8'h53;  8'h63: code = 8'h4A;
      8'h64: code = 8'h56;  8'h65: code = 8'h5B;  8'h87: code = 8'h47;
      8'h89: code = 8'h4F;  8'h8A: code = 8'h50;  8'h8B: code = 8'h51;
      8'h8C: code = 8'h52;  8'h8D: code = 8'h53;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/hid_report_to_scancode_top.sv =====
// ----------------------------------------------------------------------------
// hid_report_to_scancode_top
// Boot keyboard report to set 1 scan code translator, one word per report.
// ----------------------------------------------------------------------------
// Each accepted 8-byte report produces exactly one result word, which reaches
// the result port through the input register, then the result register; a
// new report is taken every cycle while the result side keeps up. The report
// is compared with the previously stored one: an unchanged report gives
// status 0, otherwise the lowest changed modifier among ctrl/shift/alt gives
// its make or break code, else the first newly pressed key its make code,
// else the first released key its break code (status 1), else status 0. With
// keyboard_present clear every report gives status 2 and leaves the stored
// report alone. Otherwise the stored report is updated as each report moves
// into the result register, so back-to-back reports see their predecessor.
`default_nettype none

module hid_report_to_scancode_top import hrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_modifier_bits,
  input  wire logic [7:0] in_reserved_byte,
  input  wire logic [7:0] in_key_slot_0,
  input  wire logic [7:0] in_key_slot_1,
  input  wire logic [7:0] in_key_slot_2,
  input  wire logic [7:0] in_key_slot_3,
  input  wire logic [7:0] in_key_slot_4,
  input  wire logic [7:0] in_key_slot_5,

  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_scan_code
);

  logic       kbd_present_r;

  logic       s1_vld_r;
  logic [7:0] s1_mod_r;
  logic [7:0] s1_res_r;
  slots_t     s1_slots_r;

  logic [7:0] prev_mod_r;
  logic [7:0] prev_res_r;
  slots_t     prev_slots_r;

  logic       out_vld_r;
  status_t    out_status_r;
  logic [7:0] out_code_r;

  logic       advance;
  slots_t     in_slots;
  status_t    res_status;
  logic [7:0] res_code;

  logic                same_rpt;
  logic [2:0]          mod_diff;
  logic [SLOT_MAX-1:0] pressed;
  logic [SLOT_MAX-1:0] released;
  logic [7:0]          press_usage;
  logic [7:0]          rel_usage;
  logic                press_found;
  logic                rel_found;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;

  // slots beyond KEY_SLOTS are forced empty
  always_comb begin
    in_slots = '0;
    in_slots[0] = in_key_slot_0;
    in_slots[1] = in_key_slot_1;
    in_slots[2] = in_key_slot_2;
    in_slots[3] = in_key_slot_3;
    in_slots[4] = in_key_slot_4;
    in_slots[5] = in_key_slot_5;
    for (int k = 0; k < SLOT_MAX; k++) begin
      if (k >= KEY_SLOTS) begin
        in_slots[k] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbd_present_r <= 1'b0;
    end else if (cfg_wr_en) begin
      kbd_present_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mod_r   <= in_modifier_bits;
      s1_res_r   <= in_reserved_byte;
      s1_slots_r <= in_slots;
    end
  end

  // press / release detection: every slot against every slot of the other report
  always_comb begin
    same_rpt = (s1_mod_r == prev_mod_r) && (s1_res_r == prev_res_r) &&
               (s1_slots_r == prev_slots_r);
    mod_diff = s1_mod_r[2:0] ^ prev_mod_r[2:0];
    for (int k = 0; k < SLOT_MAX; k++) begin
      pressed[k]  = (s1_slots_r[k] != 8'h00);
      released[k] = (prev_slots_r[k] != 8'h00);
      for (int p = 0; p < SLOT_MAX; p++) begin
        if (prev_slots_r[p] == s1_slots_r[k]) begin
          pressed[k] = 1'b0;
        end
        if (s1_slots_r[p] == prev_slots_r[k]) begin
          released[k] = 1'b0;
        end
      end
    end
    press_usage = 8'h00;
    press_found = 1'b0;
    rel_usage   = 8'h00;
    rel_found   = 1'b0;
    for (int k = 0; k < SLOT_MAX; k++) begin
      if (pressed[k] && !press_found) begin
        press_usage = s1_slots_r[k];
        press_found = 1'b1;
      end
      if (released[k] && !rel_found) begin
        rel_usage = prev_slots_r[k];
        rel_found = 1'b1;
      end
    end
  end

  always_comb begin
    res_status = STAT_CODE;
    res_code   = 8'h00;
    priority if (!kbd_present_r) begin
      res_status = STAT_NODEV;
    end else if (same_rpt) begin
      res_status = STAT_NONE;
    end else if (mod_diff[0]) begin
      res_code = s1_mod_r[0] ? LCTRL_MAKE : LCTRL_BREAK;
    end else if (mod_diff[1]) begin
      res_code = s1_mod_r[1] ? LSHFT_MAKE : LSHFT_BREAK;
    end else if (mod_diff[2]) begin
      res_code = s1_mod_r[2] ? LALT_MAKE : LALT_BREAK;
    end else if (press_found) begin
      res_code = usage_to_set1(press_usage);
    end else if (rel_found) begin
      res_code = usage_to_set1(rel_usage) | BREAK_BIT;
    end else begin
      res_status = STAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mod_r   <= 8'h00;
      prev_res_r   <= 8'h00;
      prev_slots_r <= '0;
    end else if (s1_vld_r && advance && kbd_present_r) begin
      prev_mod_r   <= s1_mod_r;
      prev_res_r   <= s1_res_r;
      prev_slots_r <= s1_slots_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && advance) begin
      out_status_r <= res_status;
      out_code_r   <= res_code;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_status_r;
  assign out_scan_code = out_code_r;

endmodule

`default_nettype wire

// ===== design/hrs_checker.sv =====
// ----------------------------------------------------------------------------
// hrs_checker
// Port-level checks for the HID report translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_checker import hrs_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_scan_code
);

  // nothing comes out in the cycle after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

  // status code 3 is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_NONE || out_status == STAT_CODE ||
                   out_status == STAT_NODEV))
    else $error("illegal status code");

  // words without a code carry a zero scan code
  a_no_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NONE || out_status == STAT_NODEV)
      |-> out_scan_code == 8'h00)
    else $error("scan code set without a code");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                               $stable(out_scan_code))
    else $error("stalled result word changed");

  // with the result side open, input is never blocked
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && $past(out_ready) |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind hid_report_to_scancode_top hrs_checker u_hrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_scan_code(out_scan_code)
);

`default_nettype wire

// ===== verif/hid_report_to_scancode_top_test.sv =====
// ----------------------------------------------------------------------------
// hid_report_to_scancode_top_test
// Self-checking bench for the boot report to set 1 scan code translator.
// Reports go in through a queue-fed driver, and each one is run through a
// bench-side translator holding its own copy of the stored report. Result
// words are checked field by field, in order. The run covers a directed
// opener and then phases of typed key sequences mixed with noise, under
// random stalls on both sides and with keyboard_present toggled.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_to_scancode_top_test;
  import hrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] mods;
    logic [7:0] rsvd;
    slots_t     keys;
  } report_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] code;
  } scan_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_modifier_bits = 8'h00;
  logic [7:0] in_reserved_byte = 8'h00;
  logic [7:0] in_key_slot_0 = 8'h00;
  logic [7:0] in_key_slot_1 = 8'h00;
  logic [7:0] in_key_slot_2 = 8'h00;
  logic [7:0] in_key_slot_3 = 8'h00;
  logic [7:0] in_key_slot_4 = 8'h00;
  logic [7:0] in_key_slot_5 = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_scan_code;

  hid_report_to_scancode_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_modifier_bits (in_modifier_bits),
    .in_reserved_byte (in_reserved_byte),
    .in_key_slot_0    (in_key_slot_0),
    .in_key_slot_1    (in_key_slot_1),
    .in_key_slot_2    (in_key_slot_2),
    .in_key_slot_3    (in_key_slot_3),
    .in_key_slot_4    (in_key_slot_4),
    .in_key_slot_5    (in_key_slot_5),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_scan_code    (out_scan_code)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // bench-side translator
  // --------------------------------------------------------------------------
  logic [7:0] set1_make [256];
  report_t    held_report = '0;
  bit         kbd_present = 1'b0;

  localparam logic [7:0] MOD_MAKE  [3] = '{LCTRL_MAKE, LSHFT_MAKE, LALT_MAKE};
  localparam logic [7:0] MOD_BREAK [3] = '{LCTRL_BREAK, LSHFT_BREAK, LALT_BREAK};

  initial begin
    for (int u = 0; u < 256; u++) set1_make[u] = 8'h00;
    // letters and digit row follow simple runs
    for (int u = 8'h04; u <= 8'h1D; u++) set1_make[u] = 8'(u + 8'h1A);
    for (int u = 8'h1E; u <= 8'h27; u++) set1_make[u] = 8'(2 * (u - 8'h1E) + 1);
    for (int u = 8'h3E; u <= 8'h43; u++) set1_make[u] = 8'(u + 3);
    for (int u = 8'h47; u <= 8'h4A; u++) set1_make[u] = 8'(u + 1);
    set1_make[8'h28] = 8'h1C; set1_make[8'h29] = 8'h01; set1_make[8'h2A] = 8'h0E;
    set1_make[8'h2B] = 8'h0F; set1_make[8'h2C] = 8'h2C; set1_make[8'h2D] = 8'h2D;
    set1_make[8'h2E] = 8'h01; set1_make[8'h2F] = 8'h10; set1_make[8'h30] = 8'h11;
    set1_make[8'h31] = 8'h12; set1_make[8'h32] = 8'h13; set1_make[8'h33] = 8'h17;
    set1_make[8'h34] = 8'h18; set1_make[8'h35] = 8'h19; set1_make[8'h36] = 8'h15;
    set1_make[8'h37] = 8'h2E; set1_make[8'h38] = 8'h1A; set1_make[8'h39] = 8'h3A;
    set1_make[8'h3A] = 8'h3E; set1_make[8'h3B] = 8'h3C; set1_make[8'h3C] = 8'h3D;
    set1_make[8'h3D] = 8'h3F; set1_make[8'h44] = 8'h57; set1_make[8'h45] = 8'h58;
    set1_make[8'h46] = 8'h37; set1_make[8'h4B] = 8'h51; set1_make[8'h4C] = 8'h4D;
    set1_make[8'h4D] = 8'h4E; set1_make[8'h4E] = 8'h4C; set1_make[8'h4F] = 8'h50;
    set1_make[8'h50] = 8'h4F; set1_make[8'h51] = 8'h52; set1_make[8'h52] = 8'h53;
    set1_make[8'h53] = 8'h47; set1_make[8'h54] = 8'h4B; set1_make[8'h55] = 8'h4C;
    set1_make[8'h56] = 8'h4D; set1_make[8'h57] = 8'h47; set1_make[8'h58] = 8'h49;
    set1_make[8'h59] = 8'h51; set1_make[8'h5A] = 8'h4F; set1_make[8'h5B] = 8'h50;
    set1_make[8'h5C] = 8'h51; set1_make[8'h5D] = 8'h52; set1_make[8'h5E] = 8'h4F;
    set1_make[8'h5F] = 8'h50; set1_make[8'h60] = 8'h51; set1_make[8'h61] = 8'h52;
    set1_make[8'h62] = 8'h53; set1_make[8'h63] = 8'h4A; set1_make[8'h64] = 8'h56;
    set1_make[8'h65] = 8'h5B; set1_make[8'h87] = 8'h47; set1_make[8'h89] = 8'h4F;
    set1_make[8'h8A] = 8'h50; set1_make[8'h8B] = 8'h51; set1_make[8'h8C] = 8'h52;
    set1_make[8'h8D] = 8'h53;
  end

  function automatic bit holds_usage(slots_t s, logic [7:0] u);
    for (int p = 0; p < KEY_SLOTS; p++)
      if (s[p] == u) return 1'b1;
    return 1'b0;
  endfunction

  // computes the result word for one report and, with a keyboard present, moves it into held_report
  function automatic scan_word_t translate_report(report_t raw);
    report_t    cur;
    scan_word_t res;
    logic [7:0] diff;
    bit         found;
    res   = '{status: STAT_NONE, code: 8'h00};
    found = 1'b0;
    if (!kbd_present) begin
      res.status = STAT_NODEV;
      return res;
    end
    cur = raw;
    for (int p = KEY_SLOTS; p < SLOT_MAX; p++) cur.keys[p] = 8'h00;
    if (cur != held_report) begin
      diff = cur.mods ^ held_report.mods;
      for (int b = 0; b < 3; b++) begin
        if (!found && diff[b]) begin
          found    = 1'b1;
          res.code = cur.mods[b] ? MOD_MAKE[b] : MOD_BREAK[b];
        end
      end
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (!found && cur.keys[k] != 8'h00 && !holds_usage(held_report.keys, cur.keys[k])) begin
          found    = 1'b1;
          res.code = set1_make[cur.keys[k]];
        end
      end
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (!found && held_report.keys[k] != 8'h00 &&
            !holds_usage(cur.keys, held_report.keys[k])) begin
          found    = 1'b1;
          res.code = set1_make[held_report.keys[k]] | BREAK_BIT;
        end
      end
      if (found) res.status = STAT_CODE;
    end
    held_report = cur;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // driver, receiver and checker
  // --------------------------------------------------------------------------
  report_t    pending_reports [$];
  scan_word_t expected_codes [$];
  int         fail_count = 0;
  bit         word_taken = 1'b0;
  int         send_gap = 0;
  int         hold_cnt = 0;
  bit         sender_gaps_on = 1'b1;
  bit         receiver_gaps_on = 1'b1;
  int         long_stalls_asked = 0;
  int         long_stalls_done = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      report_t seen;
      seen.mods    = in_modifier_bits;
      seen.rsvd    = in_reserved_byte;
      seen.keys[0] = in_key_slot_0;
      seen.keys[1] = in_key_slot_1;
      seen.keys[2] = in_key_slot_2;
      seen.keys[3] = in_key_slot_3;
      seen.keys[4] = in_key_slot_4;
      seen.keys[5] = in_key_slot_5;
      expected_codes.push_back(translate_report(seen));
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    report_t w;
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reports.size() != 0) begin
        w = pending_reports.pop_front();
        in_modifier_bits <= w.mods;
        in_reserved_byte <= w.rsvd;
        in_key_slot_0    <= w.keys[0];
        in_key_slot_1    <= w.keys[1];
        in_key_slot_2    <= w.keys[2];
        in_key_slot_3    <= w.keys[3];
        in_key_slot_4    <= w.keys[4];
        in_key_slot_5    <= w.keys[5];
        in_valid         <= 1'b1;
        send_gap = sender_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_stalls_asked != long_stalls_done) begin
      long_stalls_done++;
      hold_cnt = 200;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (receiver_gaps_on && $urandom_range(0, 3) == 0) begin
      hold_cnt = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      scan_word_t want;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected word status=%0d code=%02h", $time, out_status,
                 out_scan_code);
        fail_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_scan_code !== want.code) begin
          $display("%0t: scan_code expected %02h actual %02h", $time, want.code,
                   out_scan_code);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  report_t typed_state = '0;

  function automatic logic [7:0] pick_usage();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(8'h04, 8'h65));
    if (r < 88) return 8'($urandom_range(8'h87, 8'h8D));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic report_t make_report(logic [7:0] m, logic [7:0] r,
                                          logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
                                          logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
    report_t w;
    w.mods = m;
    w.rsvd = r;
    w.keys = {k5, k4, k3, k2, k1, k0};
    return w;
  endfunction

  // mostly plausible typing on top of typed_state; some raw noise
  function automatic report_t next_typed_report();
    int r;
    int s;
    report_t w;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, SLOT_MAX - 1);
    if (r < 10) begin
      w.mods = 8'($urandom);
      w.rsvd = 8'($urandom);
      for (int p = 0; p < SLOT_MAX; p++) w.keys[p] = 8'($urandom);
      return w;
    end
    if (r < 18) begin
      // repeat the same report
    end else if (r < 35) begin
      typed_state.mods[$urandom_range(0, 2)] ^= 1'b1;
    end else if (r < 40) begin
      typed_state.mods[$urandom_range(3, 7)] ^= 1'b1;
    end else if (r < 65) begin
      for (int p = 0; p < SLOT_MAX; p++) begin
        if (typed_state.keys[p] == 8'h00) begin
          s = p;
          break;
        end
      end
      typed_state.keys[s] = pick_usage();
    end else if (r < 90) begin
      typed_state.keys[s] = 8'h00;
    end else if (r < 95) begin
      typed_state.rsvd = 8'($urandom);
    end else begin
      typed_state.keys[s] = pick_usage();
      typed_state.keys[$urandom_range(0, SLOT_MAX - 1)] = 8'h00;
      typed_state.mods ^= 8'($urandom);
    end
    return typed_state;
  endfunction

  task automatic wait_idle();
    while (pending_reports.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_keyboard_present(bit v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    kbd_present = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int n_items;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no keyboard out of reset
    pending_reports.push_back(make_report(8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 8'hFF));
    wait_idle();
    write_keyboard_present(1'b1);

    pending_reports.push_back(make_report(8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h01, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h03, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h07, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h06, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'hF8, 8'h00, 0, 0, 0, 0, 0, 0));
    // upper modifier bits alone change, key press decides
    pending_reports.push_back(make_report(8'h00, 8'h00, 8'h04, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'h00, 8'h04, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'h00, 8'h04, 8'h8D, 0, 0, 0, 0));
    // unmapped usage pressed, then released
    pending_reports.push_back(make_report(8'h00, 8'h00, 8'h04, 8'h8D, 8'h66, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'h00, 0, 8'h8D, 8'h66, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'hFF, 0, 0, 8'h66, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'hFF, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 8'hFF));
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0));
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07,
                                          8'h08, 8'h09));
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07,
                                          8'h08, 8'h65));
    // press and release in one report, release is dropped
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'h87, 8'h05, 8'h06, 8'h07,
                                          8'h08, 8'h65));
    wait_idle();
    // stored report must survive a no-keyboard word
    write_keyboard_present(1'b0);
    pending_reports.push_back(make_report(8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    wait_idle();
    write_keyboard_present(1'b1);
    pending_reports.push_back(make_report(8'hFF, 8'hFF, 8'h87, 8'h05, 8'h06, 8'h07,
                                          8'h08, 8'h65));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      n_items = (ph == 2 || ph == 5) ? 60 : 280;
      if (ph == 2 || ph == 5) write_keyboard_present(1'b0);
      else if (!kbd_present) write_keyboard_present(1'b1);
      sender_gaps_on   = (ph != 1);
      receiver_gaps_on = (ph != 1);
      for (int i = 0; i < n_items; i++) pending_reports.push_back(next_typed_report());
      // receiver holds off while the sender keeps offering
      if (ph == 3) long_stalls_asked++;
      wait_idle();
    end

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/hrs_pkg.sv
design/hid_report_to_scancode_top.sv
design/hrs_checker.sv
verif/hid_report_to_scancode_top_test.sv
